[design/rqps_pkg.sv]
package rqps_pkg;

    localparam int NUM_CLASSES = 8;
    localparam int CLS_W       = 3;
    localparam int CNT_W       = 32;
    localparam int QSUM_W      = 40;
    localparam int TOT_W       = 48;
    localparam int QUAL_W      = 9;
    localparam int POSCNT_W    = 16;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 408;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_QUAL_OFFSET = 2'd0;
    localparam cfg_index_t CFG_Q20_CHAR    = 2'd1;
    localparam cfg_index_t CFG_Q30_CHAR    = 2'd2;

    localparam logic OP_BASE  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [6:0]        QUAL_OFFSET_RST = 7'd33;
    localparam logic [7:0]        Q20_CHAR_RST    = 8'd53;
    localparam logic [7:0]        Q30_CHAR_RST    = 8'd63;
    localparam logic [QUAL_W-1:0] LEAST_QUAL_RST  = 9'd127;

    typedef struct packed {
        logic [QSUM_W-1:0] qual_sum;
        logic [CNT_W-1:0]  base_cnt;
        logic [CNT_W-1:0]  q30_cnt;
        logic [CNT_W-1:0]  q20_cnt;
    } cls_entry_t;

    typedef struct packed {
        logic [QSUM_W-1:0] qual_sum;
        logic [CNT_W-1:0]  base_cnt;
    } pos_entry_t;

    typedef struct packed {
        logic              valid;
        logic              p20;
        logic              p30;
        logic [QUAL_W-1:0] qual;
    } upd_t;

    function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    function automatic logic [TOT_W-1:0] sat_inc48(input logic [TOT_W-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

endpackage

[design/rqps_store.sv]
module rqps_store #(
    parameter int MAX_POS = 512
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic [$clog2(MAX_POS)+rqps_pkg::CLS_W-1:0]   cls_addr,
    input  logic [$clog2(MAX_POS)-1:0]                   pos_addr,
    input  rqps_pkg::upd_t                               upd,
    output rqps_pkg::cls_entry_t                         cls_rdata,
    output rqps_pkg::pos_entry_t                         pos_rdata,
    output logic                                         clr_busy
);
    import rqps_pkg::*;

    localparam int POS_W  = $clog2(MAX_POS);
    localparam int CLS_AW = POS_W + CLS_W;
    localparam int DEPTH  = MAX_POS * NUM_CLASSES;

    cls_entry_t cls_mem [DEPTH];
    pos_entry_t pos_mem [MAX_POS];

    cls_entry_t        cls_rdata_reg;
    pos_entry_t        pos_rdata_reg;
    logic              clr_busy_reg, clr_busy_next;
    logic [CLS_AW-1:0] clr_addr_reg, clr_addr_next;
    cls_entry_t        cls_new;
    pos_entry_t        pos_new;

    function automatic logic [QSUM_W-1:0] add_qual(input logic [QSUM_W-1:0] s,
                                                   input logic [QUAL_W-1:0] q);
        logic signed [QSUM_W+1:0] t;
        t = $signed({2'b00, s}) + (QSUM_W+2)'($signed(q));
        if (t[QSUM_W+1]) begin
            return '0;
        end else if (t[QSUM_W]) begin
            return '1;
        end
        return t[QSUM_W-1:0];
    endfunction

    always_comb begin
        cls_new.q20_cnt  = upd.p20 ? sat_inc32(cls_rdata_reg.q20_cnt) : cls_rdata_reg.q20_cnt;
        cls_new.q30_cnt  = upd.p30 ? sat_inc32(cls_rdata_reg.q30_cnt) : cls_rdata_reg.q30_cnt;
        cls_new.base_cnt = sat_inc32(cls_rdata_reg.base_cnt);
        cls_new.qual_sum = add_qual(cls_rdata_reg.qual_sum, upd.qual);
        pos_new.base_cnt = sat_inc32(pos_rdata_reg.base_cnt);
        pos_new.qual_sum = add_qual(pos_rdata_reg.qual_sum, upd.qual);
    end

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == CLS_AW'(DEPTH - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        cls_rdata_reg <= cls_mem[cls_addr];
        if (clr_busy_reg) begin
            cls_mem[clr_addr_reg] <= '0;
        end else if (upd.valid) begin
            cls_mem[cls_addr] <= cls_new;
        end
    end

    always_ff @(posedge aclk) begin
        pos_rdata_reg <= pos_mem[pos_addr];
        if (clr_busy_reg) begin
            pos_mem[clr_addr_reg[CLS_AW-1:CLS_W]] <= '0;
        end else if (upd.valid) begin
            pos_mem[pos_addr] <= pos_new;
        end
    end

    assign cls_rdata = cls_rdata_reg;
    assign pos_rdata = pos_rdata_reg;
    assign clr_busy  = clr_busy_reg;

    a_no_update_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !upd.valid)
        else $error("update during clearing pass");

    a_clear_runs_to_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clr_busy_reg) |-> $past(clr_addr_reg) == CLS_AW'(DEPTH - 1))
        else $error("clearing pass ended early");

    a_single_update: assert property (@(posedge aclk) disable iff (!aresetn)
        upd.valid |=> !upd.valid)
        else $error("entry updated on consecutive cycles");

endmodule

[design/read_quality_position_stats.sv]
// Per-position read quality and base-content statistics.
// s_ channel: one transaction per base or query. s_tuser selects accumulate (0) or
// query (1); s_tlast marks the final base of a read.
// m_ channel: one result per query and one per final base of a read, carrying the
// running totals and, for an in-range query, the queried position and class counters.
// cfg_ channel: register writes, always ready; write only while the block is idle.
// Each in-range base does a read-modify-write of the position/class memory and the
// position memory, both read through registers; a query only reads them. A base
// is read, then modified and written back; a base that ends a read or a query
// then loads the output register. The next transaction is taken after that.
// A result waits in the output register while m_tready is low; a new transaction is
// still accepted then, and stalls only when it needs to load its own result.
// After reset a clearing pass writes zeros to every memory entry, one entry per
// cycle; s_tready stays low during it, cfg writes are taken.
module read_quality_position_stats #(
    parameter int MAX_POS = 512
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // base_code[7:0], qual_code[15:8], query_position[24:16], query_class[27:25]
    input  logic [rqps_pkg::S_DATA_W-1:0]    s_tdata,
    // operation
    input  logic                             s_tuser,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // read_count[31:0], base_total[79:32], q20_total[127:80], q30_total[175:128],
    // min_quality[184:176], max_quality[193:185], q20_at[225:194], q30_at[257:226],
    // content_at[289:258], qual_sum_at[329:290], pos_bases[361:330],
    // pos_qual_sum[401:362]
    output logic [rqps_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  rqps_pkg::cfg_index_t             cfg_index,
    input  logic [7:0]                       cfg_data
);
    import rqps_pkg::*;

    localparam int POS_W  = $clog2(MAX_POS);
    localparam int CLS_AW = POS_W + CLS_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [6:0]           qual_offset_reg, qual_offset_next;
    logic [7:0]           q20_char_reg, q20_char_next;
    logic [7:0]           q30_char_reg, q30_char_next;
    logic [POSCNT_W-1:0]  position_reg, position_next;
    logic [CNT_W-1:0]     reads_reg, reads_next;
    logic [TOT_W-1:0]     bases_reg, bases_next;
    logic [TOT_W-1:0]     q20_reg, q20_next;
    logic [TOT_W-1:0]     q30_reg, q30_next;
    logic [QUAL_W-1:0]    least_reg, least_next;
    logic [QUAL_W-1:0]    greatest_reg, greatest_next;
    logic                 op_reg, op_next;
    logic                 last_reg, last_next;
    logic                 in_range_reg, in_range_next;
    logic [7:0]           qc_reg, qc_next;
    logic [CLS_AW-1:0]    cls_addr_reg, cls_addr_next;
    logic [POS_W-1:0]     pos_addr_reg, pos_addr_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic                 s_accept;
    logic                 out_free;
    logic [CLS_AW-1:0]    cls_addr;
    logic [POS_W-1:0]     pos_addr;
    logic [POS_W-1:0]     in_pos;
    logic [CLS_W-1:0]     in_cls;
    logic                 in_range;
    logic signed [9:0]    qual_diff;
    logic [QUAL_W-1:0]    qual;
    logic                 p20;
    logic                 p30;
    logic                 show_at;
    upd_t                 upd;
    cls_entry_t           cls_rdata;
    pos_entry_t           pos_rdata;
    logic                 clr_busy;

    rqps_store #(
        .MAX_POS (MAX_POS)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cls_addr  (cls_addr),
        .pos_addr  (pos_addr),
        .upd       (upd),
        .cls_rdata (cls_rdata),
        .pos_rdata (pos_rdata),
        .clr_busy  (clr_busy)
    );

    assign s_tready  = (state_reg == ST_IDLE) && !clr_busy;
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        if (s_tuser == OP_QUERY) begin
            in_pos   = POS_W'(s_tdata[24:16]);
            in_cls   = s_tdata[27:25];
            in_range = 32'(s_tdata[24:16]) < MAX_POS;
        end else begin
            in_pos   = POS_W'(position_reg);
            in_cls   = s_tdata[2:0];
            in_range = 32'(position_reg) < MAX_POS;
        end
        if (state_reg == ST_IDLE) begin
            pos_addr = in_pos;
            cls_addr = {in_pos, in_cls};
        end else begin
            pos_addr = pos_addr_reg;
            cls_addr = cls_addr_reg;
        end
    end

    always_comb begin
        qual_diff = $signed({2'b00, qc_reg}) - $signed({3'b000, qual_offset_reg});
        qual      = qual_diff[QUAL_W-1:0];
        p30       = qc_reg > q30_char_reg;
        p20       = p30 || (qc_reg > q20_char_reg);
        upd.valid = (state_reg == ST_EXEC) && (op_reg == OP_BASE) && in_range_reg;
        upd.p20   = p20;
        upd.p30   = p30;
        upd.qual  = qual;
        show_at   = (op_reg == OP_QUERY) && in_range_reg;
    end

    always_comb begin
        state_next       = state_reg;
        qual_offset_next = qual_offset_reg;
        q20_char_next    = q20_char_reg;
        q30_char_next    = q30_char_reg;
        position_next    = position_reg;
        reads_next       = reads_reg;
        bases_next       = bases_reg;
        q20_next         = q20_reg;
        q30_next         = q30_reg;
        least_next       = least_reg;
        greatest_next    = greatest_reg;
        op_next          = op_reg;
        last_next        = last_reg;
        in_range_next    = in_range_reg;
        qc_next          = qc_reg;
        cls_addr_next    = cls_addr_reg;
        pos_addr_next    = pos_addr_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_QUAL_OFFSET: qual_offset_next = cfg_data[6:0];
                CFG_Q20_CHAR:    q20_char_next    = cfg_data;
                CFG_Q30_CHAR:    q30_char_next    = cfg_data;
                default:         ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    op_next       = s_tuser;
                    last_next     = s_tlast;
                    qc_next       = s_tdata[15:8];
                    in_range_next = in_range;
                    cls_addr_next = cls_addr;
                    pos_addr_next = pos_addr;
                    state_next    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (op_reg == OP_QUERY) begin
                    state_next = ST_OUT;
                end else begin
                    if ($signed(qual) < $signed(least_reg)) begin
                        least_next = qual;
                    end
                    if ($signed(qual) > $signed(greatest_reg)) begin
                        greatest_next = qual;
                    end
                    bases_next = sat_inc48(bases_reg);
                    if (p20) begin
                        q20_next = sat_inc48(q20_reg);
                    end
                    if (p30) begin
                        q30_next = sat_inc48(q30_reg);
                    end
                    if (last_reg) begin
                        position_next = '0;
                        reads_next    = sat_inc32(reads_reg);
                        state_next    = ST_OUT;
                    end else begin
                        if (!(&position_reg)) begin
                            position_next = position_reg + 1'b1;
                        end
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {
                        6'b000000,
                        show_at ? pos_rdata.qual_sum : {QSUM_W{1'b0}},
                        show_at ? pos_rdata.base_cnt : {CNT_W{1'b0}},
                        show_at ? cls_rdata.qual_sum : {QSUM_W{1'b0}},
                        show_at ? cls_rdata.base_cnt : {CNT_W{1'b0}},
                        show_at ? cls_rdata.q30_cnt  : {CNT_W{1'b0}},
                        show_at ? cls_rdata.q20_cnt  : {CNT_W{1'b0}},
                        greatest_reg,
                        least_reg,
                        q30_reg,
                        q20_reg,
                        bases_reg,
                        reads_reg
                    };
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            qual_offset_reg <= QUAL_OFFSET_RST;
            q20_char_reg    <= Q20_CHAR_RST;
            q30_char_reg    <= Q30_CHAR_RST;
            position_reg    <= '0;
            reads_reg       <= '0;
            bases_reg       <= '0;
            q20_reg         <= '0;
            q30_reg         <= '0;
            least_reg       <= LEAST_QUAL_RST;
            greatest_reg    <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            qual_offset_reg <= qual_offset_next;
            q20_char_reg    <= q20_char_next;
            q30_char_reg    <= q30_char_next;
            position_reg    <= position_next;
            reads_reg       <= reads_next;
            bases_reg       <= bases_next;
            q20_reg         <= q20_next;
            q30_reg         <= q30_next;
            least_reg       <= least_next;
            greatest_reg    <= greatest_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        last_reg     <= last_next;
        in_range_reg <= in_range_next;
        qc_reg       <= qc_next;
        cls_addr_reg <= cls_addr_next;
        pos_addr_reg <= pos_addr_next;
        m_tdata_reg  <= m_tdata_next;
    end

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result loaded outside output state");

    a_min_below_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (bases_reg != '0) |-> $signed(least_reg) <= $signed(greatest_reg))
        else $error("least quality above greatest quality");

    a_position_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC && op_reg == OP_BASE && last_reg) |=> position_reg == '0)
        else $error("position not restarted after last base");

endmodule
